// ===== rtl/atte_pkg.sv =====
// shared types, codes and helper functions of the ansi text terminal engine
// no dependencies; used by every module of the block
package atte_pkg;

  // result kinds as they appear on the master tuser
  typedef enum logic [1:0] {
    CMD_DRAW   = 2'd0,
    CMD_FILL   = 2'd1,
    CMD_SCROLL = 2'd2
  } cmd_t;

  // parser modes
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_CSI    = 2'd2
  } mode_t;

  // configuration register indexes
  localparam logic [2:0] REG_TEXT_COLUMNS  = 3'd0;
  localparam logic [2:0] REG_TEXT_ROWS     = 3'd1;
  localparam logic [2:0] REG_CELL_WIDTH    = 3'd2;
  localparam logic [2:0] REG_CELL_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd5;

  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned TDATA_W    = 104;

  // byte codes
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_QUEST    = 8'h3F;
  localparam logic [7:0] CH_0        = 8'h30;
  localparam logic [7:0] CH_9        = 8'h39;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_FIN_C    = 8'h43;
  localparam logic [7:0] CH_FIN_D    = 8'h44;
  localparam logic [7:0] CH_FIN_G    = 8'h47;
  localparam logic [7:0] CH_FIN_H    = 8'h48;
  localparam logic [7:0] CH_FIN_J    = 8'h4A;
  localparam logic [7:0] CH_FIN_K    = 8'h4B;
  localparam logic [7:0] CH_FIN_M    = 8'h6D;
  localparam logic [7:0] CH_FIN_S    = 8'h73;
  localparam logic [7:0] CH_FIN_U    = 8'h75;
  localparam logic [7:0] CSI_BYTE_MIN = 8'h20;
  localparam logic [7:0] CSI_BYTE_MAX = 8'hFE;

  localparam logic [23:0] COLOUR_WHITE = 24'hFFFFFF;
  localparam logic [23:0] COLOUR_BLACK = 24'h000000;
  localparam logic [15:0] PARAM_MAX    = 16'hFFFF;
  localparam logic [15:0] PIX_MAX      = 16'd4095;

  typedef struct packed {
    logic [8:0]  cols_eff;
    logic [8:0]  rows_eff;
    logic [5:0]  cell_width;
    logic [6:0]  cell_height;
    logic [11:0] screen_width;
    logic [11:0] screen_height;
  } cfg_t;

  typedef struct packed {
    cmd_t        command;
    logic [11:0] rect_x;
    logic [11:0] rect_y;
    logic [11:0] rect_w;
    logic [11:0] rect_h;
    logic [7:0]  glyph;
    logic [23:0] fore_colour;
    logic [23:0] back_colour;
    logic        last;
  } result_t;

  function automatic logic [11:0] sat12(input logic [15:0] v);
    return (v > PIX_MAX) ? 12'hFFF : v[11:0];
  endfunction

  // a - b floored at zero
  function automatic logic [11:0] subsat12(input logic [11:0] a, input logic [15:0] b);
    return (16'(a) > b) ? 12'(16'(a) - b) : 12'd0;
  endfunction

  // sgr palette, normal and bright rows
  function automatic logic [23:0] sgr_colour(input logic bright, input logic [2:0] idx);
    logic [23:0] c;
    case ({bright, idx})
      4'd0:    c = 24'h555555;
      4'd1:    c = 24'hFF5555;
      4'd2:    c = 24'h55FF55;
      4'd3:    c = 24'hFFFF55;
      4'd4:    c = 24'h5555FF;
      4'd5:    c = 24'hFF55FF;
      4'd6:    c = 24'h55FFFF;
      4'd8:    c = 24'hAAAAAA;
      4'd9:    c = 24'hFFAAAA;
      4'd10:   c = 24'hAAFFAA;
      4'd11:   c = 24'hFFFFAA;
      4'd12:   c = 24'hAAAAFF;
      4'd13:   c = 24'hFFAAFF;
      4'd14:   c = 24'hAAFFFF;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

  function automatic result_t make_res(input cmd_t cmd, input logic [15:0] x,
                                       input logic [15:0] y, input logic [15:0] w,
                                       input logic [15:0] h, input logic [7:0] g,
                                       input logic [23:0] fc, input logic [23:0] bc);
    result_t r;
    r.command     = cmd;
    r.rect_x      = sat12(x);
    r.rect_y      = sat12(y);
    r.rect_w      = sat12(w);
    r.rect_h      = sat12(h);
    r.glyph       = g;
    r.fore_colour = fc;
    r.back_colour = bc;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/atte_cfg_regs.sv =====
// configuration registers of the terminal engine, with zero grid sizes mapped to one
// depends on atte_pkg
module atte_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_index,
  input  logic [atte_pkg::CFG_DATA_W-1:0]   cfg_data,
  output atte_pkg::cfg_t                    grid
);

  logic [8:0]  text_columns;
  logic [8:0]  text_rows;
  logic [5:0]  cell_width;
  logic [6:0]  cell_height;
  logic [11:0] screen_width;
  logic [11:0] screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_columns  <= 9'd80;
      text_rows     <= 9'd25;
      cell_width    <= 6'd8;
      cell_height   <= 7'd16;
      screen_width  <= 12'd640;
      screen_height <= 12'd400;
    end else if (cfg_we) begin
      unique case (cfg_index)
        atte_pkg::REG_TEXT_COLUMNS:  text_columns  <= cfg_data[8:0];
        atte_pkg::REG_TEXT_ROWS:     text_rows     <= cfg_data[8:0];
        atte_pkg::REG_CELL_WIDTH:    cell_width    <= cfg_data[5:0];
        atte_pkg::REG_CELL_HEIGHT:   cell_height   <= cfg_data[6:0];
        atte_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data[11:0];
        atte_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    grid.cols_eff      = (text_columns == '0) ? 9'd1 : text_columns;
    grid.rows_eff      = (text_rows == '0) ? 9'd1 : text_rows;
    grid.cell_width    = cell_width;
    grid.cell_height   = cell_height;
    grid.screen_width  = screen_width;
    grid.screen_height = screen_height;
  end

endmodule

// ===== rtl/atte_parser.sv =====
// escape parser, cursor and colour state, and command generation for one byte
// depends on atte_pkg; fed by the input register, feeds the output buffer
module atte_parser (
  input  logic              clk,
  input  logic              rst,
  input  atte_pkg::cfg_t    grid,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              res_ready,
  output logic              step_done,
  output logic              res_push,
  output atte_pkg::result_t res_data
);

  atte_pkg::mode_t parse_mode, parse_mode_next;
  logic        pf_abs, pf_abs_next;
  logic [15:0] pf_val, pf_val_next;
  logic        ps_abs, ps_abs_next;
  logic [15:0] ps_val, ps_val_next;
  logic [1:0]  param_slot, param_slot_next;
  logic [8:0]  cursor_col, cursor_col_next;
  logic [8:0]  cursor_row, cursor_row_next;
  logic [8:0]  saved_col, saved_col_next;
  logic [8:0]  saved_row, saved_row_next;
  logic [23:0] fore_reg, fore_next;
  logic [23:0] back_reg, back_next;
  logic        phase, phase_next;

  logic [8:0]  cols_m1, rows_m1;
  logic [15:0] px_full, py_full, y1_full, scroll_full;
  logic [9:0]  col_t, row_t, scroll_k;
  logic        glyph_hit, scroll_hit;
  logic [15:0] acc_base;
  logic [19:0] acc_wide;
  logic [15:0] acc_sat;
  logic [15:0] d_val;
  logic [16:0] col_sum;
  logic [8:0]  col_diff;
  logic [11:0] k_x;
  atte_pkg::result_t res_a, res_b, glyph_res, scroll_res;
  logic [1:0]  nres;

  function automatic logic [8:0] clamp_pos(input logic absent, input logic [15:0] val,
                                           input logic [8:0] lim);
    if (absent || val == '0) return 9'd0;
    else if (val >= 16'(lim)) return lim - 9'd1;
    else return 9'(val - 16'd1);
  endfunction

  assign cols_m1 = grid.cols_eff - 9'd1;
  assign rows_m1 = grid.rows_eff - 9'd1;

  // pixel position of the cursor cell
  assign px_full = 16'(cursor_col) * 16'(grid.cell_width);
  assign py_full = 16'(cursor_row) * 16'(grid.cell_height);
  assign y1_full = py_full + 16'(grid.cell_height);

  // normal-mode cursor motion, wrap and scroll
  always_comb begin
    col_t     = {1'b0, cursor_col};
    row_t     = {1'b0, cursor_row};
    glyph_hit = 1'b0;
    unique case (in_byte)
      atte_pkg::CH_ESC: glyph_hit = 1'b0;
      atte_pkg::CH_LF: begin
        col_t = '0;
        row_t = row_t + 10'd1;
      end
      atte_pkg::CH_CR: col_t = '0;
      atte_pkg::CH_BS: begin
        if (cursor_col != '0) col_t = col_t - 10'd1;
      end
      default: begin
        glyph_hit = 1'b1;
        col_t     = col_t + 10'd1;
      end
    endcase
    if (col_t >= {1'b0, grid.cols_eff}) begin
      col_t = '0;
      row_t = row_t + 10'd1;
    end
    scroll_hit = (row_t >= {1'b0, grid.rows_eff});
    scroll_k   = row_t - {1'b0, grid.rows_eff} + 10'd1;
    if (scroll_hit) row_t = {1'b0, rows_m1};
  end

  assign scroll_full = 16'(scroll_k) * 16'(grid.cell_height);

  // decimal field accumulation, saturating
  assign acc_base = (param_slot == 2'd0) ? (pf_abs ? 16'd0 : pf_val)
                                         : (ps_abs ? 16'd0 : ps_val);
  assign acc_wide = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0}
                  + 20'(in_byte[3:0]);
  assign acc_sat  = (acc_wide > 20'(atte_pkg::PARAM_MAX)) ? atte_pkg::PARAM_MAX
                                                         : acc_wide[15:0];

  assign d_val    = pf_abs ? 16'd1 : pf_val;
  assign col_sum  = 17'(cursor_col) + 17'(d_val);
  assign col_diff = cursor_col - d_val[8:0];
  assign k_x      = (pf_abs || pf_val == '0) ? atte_pkg::sat12(px_full) : 12'd0;

  always_comb begin
    glyph_res  = atte_pkg::make_res(atte_pkg::CMD_DRAW, px_full, py_full,
                                    16'(grid.cell_width), 16'(grid.cell_height),
                                    in_byte, fore_reg, back_reg);
    scroll_res = atte_pkg::make_res(atte_pkg::CMD_SCROLL, 16'd0,
                   16'(atte_pkg::subsat12(grid.screen_height, scroll_full)),
                   16'(grid.screen_width), scroll_full, 8'd0, fore_reg, back_reg);
  end

  always_comb begin
    parse_mode_next = parse_mode;
    pf_abs_next     = pf_abs;
    pf_val_next     = pf_val;
    ps_abs_next     = ps_abs;
    ps_val_next     = ps_val;
    param_slot_next = param_slot;
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    saved_col_next  = saved_col;
    saved_row_next  = saved_row;
    fore_next       = fore_reg;
    back_next       = back_reg;
    res_a           = glyph_res;
    res_b           = scroll_res;
    nres            = 2'd0;

    unique case (parse_mode)
      atte_pkg::MODE_ESC: begin
        if (in_byte == atte_pkg::CH_LBRACKET) begin
          parse_mode_next = atte_pkg::MODE_CSI;
          param_slot_next = 2'd0;
          pf_abs_next     = 1'b1;
          ps_abs_next     = 1'b1;
        end else begin
          parse_mode_next = atte_pkg::MODE_NORMAL;
        end
      end

      atte_pkg::MODE_CSI: begin
        if (in_byte < atte_pkg::CSI_BYTE_MIN || in_byte > atte_pkg::CSI_BYTE_MAX) begin
          parse_mode_next = atte_pkg::MODE_NORMAL;
        end else begin
          unique case (in_byte) inside
            atte_pkg::CH_SEMI: begin
              if (param_slot != 2'd2) param_slot_next = param_slot + 2'd1;
            end
            atte_pkg::CH_QUEST: parse_mode_next = atte_pkg::MODE_CSI;
            [atte_pkg::CH_0:atte_pkg::CH_9]: begin
              if (param_slot == 2'd0) begin
                pf_abs_next = 1'b0;
                pf_val_next = acc_sat;
              end else if (param_slot == 2'd1) begin
                ps_abs_next = 1'b0;
                ps_val_next = acc_sat;
              end
            end
            default: begin
              // any other byte is a final
              parse_mode_next = atte_pkg::MODE_NORMAL;
              unique case (in_byte)
                atte_pkg::CH_FIN_C: begin
                  cursor_col_next = (col_sum > 17'(cols_m1)) ? cols_m1 : col_sum[8:0];
                end
                atte_pkg::CH_FIN_D: begin
                  if (16'(cursor_col) >= d_val)
                    cursor_col_next = (col_diff > cols_m1) ? cols_m1 : col_diff;
                  else
                    cursor_col_next = 9'd0;
                end
                atte_pkg::CH_FIN_G: begin
                  cursor_col_next = clamp_pos(pf_abs, pf_val, grid.cols_eff);
                end
                atte_pkg::CH_FIN_H: begin
                  cursor_row_next = clamp_pos(pf_abs, pf_val, grid.rows_eff);
                  cursor_col_next = clamp_pos(ps_abs, ps_val, grid.cols_eff);
                end
                atte_pkg::CH_FIN_J: begin
                  if (pf_abs || pf_val == '0) begin
                    // cursor to end of screen
                    res_a = atte_pkg::make_res(atte_pkg::CMD_FILL, px_full, py_full,
                              16'(atte_pkg::subsat12(grid.screen_width, px_full)),
                              16'(grid.cell_height), 8'd0, fore_reg, back_reg);
                    res_b = atte_pkg::make_res(atte_pkg::CMD_FILL, 16'd0, y1_full,
                              16'(grid.screen_width),
                              16'(atte_pkg::subsat12(grid.screen_height, y1_full)),
                              8'd0, fore_reg, back_reg);
                    nres  = 2'd2;
                  end else if (pf_val == 16'd1) begin
                    // start of screen to cursor
                    res_a = atte_pkg::make_res(atte_pkg::CMD_FILL, 16'd0, py_full,
                              px_full, 16'(grid.cell_height), 8'd0, fore_reg, back_reg);
                    res_b = atte_pkg::make_res(atte_pkg::CMD_FILL, 16'd0, 16'd0,
                              16'(grid.screen_width), py_full, 8'd0, fore_reg, back_reg);
                    nres  = 2'd2;
                  end else begin
                    res_a = atte_pkg::make_res(atte_pkg::CMD_FILL, 16'd0, 16'd0,
                              16'(grid.screen_width), 16'(grid.screen_height), 8'd0,
                              fore_reg, back_reg);
                    nres  = 2'd1;
                  end
                end
                atte_pkg::CH_FIN_K: begin
                  res_a = atte_pkg::make_res(atte_pkg::CMD_FILL, 16'(k_x), py_full,
                            (!pf_abs && pf_val == 16'd1) ? px_full
                              : 16'(atte_pkg::subsat12(grid.screen_width, 16'(k_x))),
                            16'(grid.cell_height), 8'd0, fore_reg, back_reg);
                  nres  = 2'd1;
                end
                atte_pkg::CH_FIN_M: begin
                  if (pf_abs || pf_val == '0) begin
                    fore_next = atte_pkg::COLOUR_WHITE;
                    back_next = atte_pkg::COLOUR_BLACK;
                  end else if (pf_val >= 16'd30 && pf_val <= 16'd37) begin
                    fore_next = atte_pkg::sgr_colour(1'b0, 3'(pf_val - 16'd30));
                  end else if (pf_val >= 16'd40 && pf_val <= 16'd47) begin
                    back_next = atte_pkg::sgr_colour(1'b0, 3'(pf_val - 16'd40));
                  end else if (pf_val >= 16'd90 && pf_val <= 16'd97) begin
                    fore_next = atte_pkg::sgr_colour(1'b1, 3'(pf_val - 16'd90));
                  end else if (pf_val >= 16'd100 && pf_val <= 16'd107) begin
                    back_next = atte_pkg::sgr_colour(1'b1, 3'(pf_val - 16'd100));
                  end
                end
                atte_pkg::CH_FIN_S: begin
                  saved_col_next = cursor_col;
                  saved_row_next = cursor_row;
                end
                atte_pkg::CH_FIN_U: begin
                  cursor_col_next = saved_col;
                  cursor_row_next = saved_row;
                end
                default: parse_mode_next = atte_pkg::MODE_NORMAL;
              endcase
            end
          endcase
        end
      end

      default: begin
        parse_mode_next = (in_byte == atte_pkg::CH_ESC) ? atte_pkg::MODE_ESC
                                                        : atte_pkg::MODE_NORMAL;
        cursor_col_next = col_t[8:0];
        cursor_row_next = row_t[8:0];
        res_a           = glyph_hit ? glyph_res : scroll_res;
        res_b           = scroll_res;
        nres            = 2'(glyph_hit) + 2'(scroll_hit);
      end
    endcase
  end

  // two-result bytes hand out the first result in phase 0 and commit in phase 1
  always_comb begin
    res_push  = in_valid && (nres != 2'd0) && res_ready;
    step_done = in_valid && ((nres == 2'd0) || res_ready) && !((nres == 2'd2) && !phase);
    if (phase) begin
      res_data      = res_b;
      res_data.last = 1'b1;
    end else begin
      res_data      = res_a;
      res_data.last = (nres == 2'd1);
    end
    if (res_push && (nres == 2'd2) && !phase) phase_next = 1'b1;
    else if (step_done)                       phase_next = 1'b0;
    else                                      phase_next = phase;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode <= atte_pkg::MODE_NORMAL;
      pf_abs     <= 1'b1;
      pf_val     <= '0;
      ps_abs     <= 1'b1;
      ps_val     <= '0;
      param_slot <= '0;
      cursor_col <= '0;
      cursor_row <= '0;
      saved_col  <= '0;
      saved_row  <= '0;
      fore_reg   <= atte_pkg::COLOUR_WHITE;
      back_reg   <= atte_pkg::COLOUR_BLACK;
      phase      <= 1'b0;
    end else begin
      phase <= phase_next;
      if (step_done) begin
        parse_mode <= parse_mode_next;
        pf_abs     <= pf_abs_next;
        pf_val     <= pf_val_next;
        ps_abs     <= ps_abs_next;
        ps_val     <= ps_val_next;
        param_slot <= param_slot_next;
        cursor_col <= cursor_col_next;
        cursor_row <= cursor_row_next;
        saved_col  <= saved_col_next;
        saved_row  <= saved_row_next;
        fore_reg   <= fore_next;
        back_reg   <= back_next;
      end
    end
  end

endmodule

// ===== rtl/atte_out_buf.sv =====
// output register with skid stage, packs results onto the master stream
// depends on atte_pkg
module atte_out_buf (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  atte_pkg::result_t              push_data,
  output logic                           ready,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [atte_pkg::TDATA_W-1:0]   m_tdata,
  output logic [1:0]                     m_tuser,
  output logic                           m_tlast
);

  atte_pkg::result_t out_reg, skid_reg;
  logic              out_valid, skid_valid;

  assign ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_reg <= skid_valid ? skid_reg : push_data;
    end else if (push) begin
      skid_reg <= push_data;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_reg.back_colour, out_reg.fore_colour, out_reg.glyph,
                     out_reg.rect_h, out_reg.rect_w, out_reg.rect_y, out_reg.rect_x};
  assign m_tuser  = out_reg.command;
  assign m_tlast  = out_reg.last;

endmodule

// ===== rtl/ansi_text_terminal_engine_core.sv =====
// top level of the ansi text terminal engine: byte stream in, drawing commands out
// depends on atte_pkg, atte_cfg_regs, atte_parser, atte_out_buf

// The engine takes one byte of terminal output per slave request and turns it into
// zero, one or two pixel-unit commands (draw glyph cell, fill rectangle, scroll up),
// tracking cursor, saved cursor, colours and an ESC / CSI parser. A byte is taken
// every cycle while the output keeps up; a byte that yields two commands (a partial
// erase in display, or a glyph followed by a scroll) holds the step logic until both
// are out, since the single result path into the output register carries one command
// per cycle. From slave request to master request a byte passes the input register,
// then the result register. The output register has a skid stage, so a stalled
// master side holds back the slave side only once that stage fills. Configuration
// writes take effect at the next clock edge and belong in idle periods only.
module ansi_text_terminal_engine_core (
  input  logic                           clk,
  input  logic                           rst,
  // slave stream: byte_in
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] byte_in
  // master stream: one command per request
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [11:0] rect_x, [23:12] rect_y, [35:24] rect_w, [47:36] rect_h,
  // [55:48] glyph, [79:56] fore_colour, [103:80] back_colour
  output logic [atte_pkg::TDATA_W-1:0]   m_tdata,
  output logic [1:0]                     m_tuser,   // [1:0] command
  output logic                           m_tlast,   // last command of this byte
  // configuration write port
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [atte_pkg::CFG_DATA_W-1:0] cfg_data
);

  atte_pkg::cfg_t    grid;
  atte_pkg::result_t res_data;
  logic              in_valid;
  logic [7:0]        in_byte;
  logic              step_done;
  logic              res_push;
  logic              res_ready;

  // input register: freed when the step logic commits the held byte
  assign s_tready = !in_valid || step_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // grid and surface geometry
  atte_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .grid      (grid)
  );

  // parser, cursor and colour state; one command per cycle while the output is ready
  atte_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .grid      (grid),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .res_ready (res_ready),
    .step_done (step_done),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // result register and skid stage
  atte_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .ready     (res_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // a held byte stays put until its step commits
  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    in_valid && !step_done |=> in_valid && $stable(in_byte))
    else $error("input byte lost before its step committed");

  // after the first of two commands the same byte is still in the input register
  a_second_pending: assert property (@(posedge clk) disable iff (rst)
    res_push && !res_data.last |=> in_valid && $stable(in_byte))
    else $error("byte released before its second command");

  // a scroll is always the final command of its byte
  a_scroll_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == 2'(atte_pkg::CMD_SCROLL) |-> m_tlast)
    else $error("scroll command not marked last");

endmodule
